/* src/shpc_pkg.sv */
// ----------------------------------------------------------------------------
// shpc_pkg
// Shared types and constants of the salted PIN hash check: register codes,
// FNV-1a constants and the shift schedule of the serial multiplier.
// ----------------------------------------------------------------------------
package shpc_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam int unsigned HASH_BYTES = 32;
    localparam int unsigned SALT_BYTES = 16;

    // The FNV prime 2^40 + 0x1B3 has set bits 0, 1, 4, 5, 7, 8 and 40.
    localparam logic [2:0] MUL_LAST = 3'd6;

    localparam logic [3:0] SEED_LAST  = 4'(SALT_BYTES - 1);
    localparam logic [4:0] ROUND_LAST = 5'(HASH_BYTES - 1);

    typedef enum logic [2:0] {
        REG_CODE_LEN   = 3'd0,
        REG_SALT_LOW   = 3'd1,
        REG_SALT_HIGH  = 3'd2,
        REG_EXP_HASH_0 = 3'd3,
        REG_EXP_HASH_1 = 3'd4,
        REG_EXP_HASH_2 = 3'd5,
        REG_EXP_HASH_3 = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [7:0]       code_len;
        logic [63:0]      salt_low;
        logic [63:0]      salt_high;
        logic [3:0][63:0] expected_hash;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } mix_req_t;

    function automatic logic [5:0] mul_shift(input logic [2:0] step);
        logic [5:0] amount;
        unique case (step)
            3'd0:    amount = 6'd0;
            3'd1:    amount = 6'd1;
            3'd2:    amount = 6'd4;
            3'd3:    amount = 6'd5;
            3'd4:    amount = 6'd7;
            3'd5:    amount = 6'd8;
            3'd6:    amount = 6'd40;
            default: amount = 6'd0;
        endcase
        return amount;
    endfunction

endpackage

/* src/shpc_regs.sv */
// ----------------------------------------------------------------------------
// shpc_regs
// Configuration registers behind a 64-bit APB-style port, one register
// every eight bytes.
// ----------------------------------------------------------------------------
module shpc_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    output shpc_pkg::cfg_t       cfg
);

    shpc_pkg::cfg_t       cfg_reg;
    shpc_pkg::reg_index_t index;
    logic                 wr_en;

    assign index  = shpc_pkg::reg_index_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (index)
                shpc_pkg::REG_CODE_LEN:   cfg_reg.code_len         <= pwdata[7:0];
                shpc_pkg::REG_SALT_LOW:   cfg_reg.salt_low         <= pwdata;
                shpc_pkg::REG_SALT_HIGH:  cfg_reg.salt_high        <= pwdata;
                shpc_pkg::REG_EXP_HASH_0: cfg_reg.expected_hash[0] <= pwdata;
                shpc_pkg::REG_EXP_HASH_1: cfg_reg.expected_hash[1] <= pwdata;
                shpc_pkg::REG_EXP_HASH_2: cfg_reg.expected_hash[2] <= pwdata;
                shpc_pkg::REG_EXP_HASH_3: cfg_reg.expected_hash[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            shpc_pkg::REG_CODE_LEN:   prdata = {56'd0, cfg_reg.code_len};
            shpc_pkg::REG_SALT_LOW:   prdata = cfg_reg.salt_low;
            shpc_pkg::REG_SALT_HIGH:  prdata = cfg_reg.salt_high;
            shpc_pkg::REG_EXP_HASH_0: prdata = cfg_reg.expected_hash[0];
            shpc_pkg::REG_EXP_HASH_1: prdata = cfg_reg.expected_hash[1];
            shpc_pkg::REG_EXP_HASH_2: prdata = cfg_reg.expected_hash[2];
            shpc_pkg::REG_EXP_HASH_3: prdata = cfg_reg.expected_hash[3];
            default:                  prdata = '0;
        endcase
    end

endmodule

/* src/shpc_mixer.sv */
// ----------------------------------------------------------------------------
// shpc_mixer
// Serial multiplier by the FNV prime: one shifted partial product per
// cycle, seven partial products in all, result flagged by a one-cycle done.
// ----------------------------------------------------------------------------
module shpc_mixer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shpc_pkg::mix_req_t   req,
    output logic                 done,
    output logic [63:0]          result
);

    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    assign acc_next = acc_reg + (x_reg << shpc_pkg::mul_shift(step_reg));
    assign done     = done_reg;
    assign result   = acc_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == shpc_pkg::MUL_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            x_reg   <= req.value;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* src/salted_pin_hash_check.sv */
// ----------------------------------------------------------------------------
// salted_pin_hash_check
// Salted FNV-1a 64 PIN hash with a 32-byte expansion and a match check.
//
// The input channel takes one PIN character per item (digit, has_digit,
// last). The first item of a PIN seeds the chain with the offset basis and
// the 16 salt bytes. Every valid character is mixed into the chain. An item
// marked last starts 32 expansion rounds, and each round sends one item on
// the output channel: hash_byte, byte_index, and on the 32nd item last_byte
// and the match flag. Configuration is to be written over the APB port only
// while the block is idle; the block itself does not enforce this.
// Each mix is a multiply by the FNV prime in a serial shift-add unit. The
// first item of a PIN mixes the 16 salt bytes before its own character, and
// the last item adds the 32 expansion rounds, one output item per round.
// Reset clears the control and output registers and closes any open PIN;
// the captured input item and the mixer operands are not reset. When the
// receiver stalls, the output register holds its item and the expansion
// waits; the next input is taken while the final output item still waits.
// ----------------------------------------------------------------------------
module salted_pin_hash_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  digit,
    input  logic        has_digit,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  hash_byte,
    output logic [4:0]  byte_index,
    output logic        match,
    output logic        last_byte
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_SEED_WAIT,
        S_DIGIT,
        S_DIGIT_WAIT,
        S_EXPAND,
        S_EXPAND_WAIT,
        S_EMIT
    } state_t;

    shpc_pkg::cfg_t     cfg;
    shpc_pkg::mix_req_t mix_req;
    logic               mix_done;
    logic [63:0]        mix_result;

    state_t      state_reg;
    logic [63:0] chain_reg;
    logic [7:0]  count_reg;
    logic        overflow_reg;
    logic        pin_open_reg;
    logic        mismatch_reg;
    logic [3:0]  seed_idx_reg;
    logic [4:0]  round_reg;
    logic [7:0]  digit_reg;
    logic        has_digit_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic [7:0]  hash_byte_reg;
    logic [4:0]  byte_index_reg;
    logic        match_reg;
    logic        last_byte_reg;

    logic [127:0] salt;
    logic [7:0]   salt_byte;
    logic [7:0]   round_byte;
    logic [7:0]   chain_byte;
    logic [7:0]   want_byte;
    logic         mismatch_next;
    logic         out_free;
    logic         emit;
    logic         in_accept;

    shpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shpc_mixer u_mixer (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mix_req),
        .done   (mix_done),
        .result (mix_result)
    );

    assign salt       = {cfg.salt_high, cfg.salt_low};
    assign salt_byte  = salt[{seed_idx_reg, 3'b000} +: 8];
    assign round_byte = {round_reg[3:0], 4'b0000} + {3'b000, round_reg} + count_reg;
    assign chain_byte = chain_reg[{round_reg[2:0], 3'b000} +: 8];
    assign want_byte  = cfg.expected_hash[round_reg[4:3]][{round_reg[2:0], 3'b000} +: 8];
    assign mismatch_next = mismatch_reg || (chain_byte != want_byte);

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == S_EMIT) && out_free;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb begin
        mix_req = '0;
        unique case (state_reg)
            S_SEED: begin
                mix_req.start = 1'b1;
                mix_req.value = chain_reg ^ {56'd0, salt_byte};
            end
            S_DIGIT: begin
                mix_req.start = has_digit_reg;
                mix_req.value = chain_reg ^ {56'd0, digit_reg};
            end
            S_EXPAND: begin
                mix_req.start = 1'b1;
                mix_req.value = chain_reg ^ {56'd0, round_byte};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            chain_reg      <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            pin_open_reg   <= 1'b0;
            mismatch_reg   <= 1'b0;
            seed_idx_reg   <= '0;
            round_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hash_byte_reg  <= '0;
            byte_index_reg <= '0;
            match_reg      <= 1'b0;
            last_byte_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall && !emit) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        if (!pin_open_reg) begin
                            chain_reg    <= shpc_pkg::FNV_BASIS;
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            mismatch_reg <= 1'b0;
                            seed_idx_reg <= '0;
                            state_reg    <= S_SEED;
                        end else begin
                            state_reg <= S_DIGIT;
                        end
                    end
                end
                S_SEED: begin
                    state_reg <= S_SEED_WAIT;
                end
                S_SEED_WAIT: begin
                    if (mix_done) begin
                        chain_reg <= mix_result;
                        if (seed_idx_reg == shpc_pkg::SEED_LAST) begin
                            pin_open_reg <= 1'b1;
                            state_reg    <= S_DIGIT;
                        end else begin
                            seed_idx_reg <= seed_idx_reg + 4'd1;
                            state_reg    <= S_SEED;
                        end
                    end
                end
                S_DIGIT: begin
                    round_reg <= '0;
                    if (has_digit_reg) begin
                        if (count_reg == 8'hFF) begin
                            overflow_reg <= 1'b1;
                        end
                        count_reg <= count_reg + 8'd1;
                        state_reg <= S_DIGIT_WAIT;
                    end else if (last_reg) begin
                        mismatch_reg <= overflow_reg || (count_reg != cfg.code_len);
                        state_reg    <= S_EXPAND;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIGIT_WAIT: begin
                    if (mix_done) begin
                        chain_reg <= mix_result;
                        if (last_reg) begin
                            mismatch_reg <= overflow_reg || (count_reg != cfg.code_len);
                            state_reg    <= S_EXPAND;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EXPAND: begin
                    state_reg <= S_EXPAND_WAIT;
                end
                S_EXPAND_WAIT: begin
                    if (mix_done) begin
                        chain_reg <= mix_result;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        hash_byte_reg  <= chain_byte;
                        byte_index_reg <= round_reg;
                        mismatch_reg   <= mismatch_next;
                        if (round_reg == shpc_pkg::ROUND_LAST) begin
                            match_reg     <= !mismatch_next;
                            last_byte_reg <= 1'b1;
                            pin_open_reg  <= 1'b0;
                            state_reg     <= S_IDLE;
                        end else begin
                            match_reg     <= 1'b0;
                            last_byte_reg <= 1'b0;
                            round_reg     <= round_reg + 5'd1;
                            state_reg     <= S_EXPAND;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept) begin
            digit_reg     <= digit;
            has_digit_reg <= has_digit;
            last_reg      <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_byte  = hash_byte_reg;
    assign byte_index = byte_index_reg;
    assign match      = match_reg;
    assign last_byte  = last_byte_reg;

endmodule
